### hdl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// LRU stack distance package
// Shared constants and the control word that the stack cells receive.
// ----------------------------------------------------------------------------
package lsd_pkg;

   // Default geometry of the stack.
   localparam int STACK_DEPTH_DEF = 16;
   localparam int PAGE_BITS_DEF   = 32;

   // Fixed field widths of the register and result words.
   localparam int CAP_W   = 5;
   localparam int DEPTH_W = 4;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Per-cell control for one lookup.
   typedef struct packed {
      logic go;     // a word is being processed this cycle
      logic hit;    // the word was found somewhere in the stack
      logic valid;  // this cell lies inside the filled part of the stack
      logic ins;    // this cell shifts on a miss (insert at the MRU end)
   } lsd_cell_ctrl_type;

endpackage

### hdl/lsd_cell.sv
// ----------------------------------------------------------------------------
// LRU stack cell
// Holds one stack entry, compares it with the looked-up page and takes its
// left neighbour's entry when the stack shifts down past it.
// ----------------------------------------------------------------------------
module lsd_cell import lsd_pkg::*; #(
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  lsd_cell_ctrl_type     ctrl,
   input  logic [PAGE_BITS-1:0]  page,
   input  logic [PAGE_BITS-1:0]  left_entry,
   input  logic                  found_left,
   output logic [PAGE_BITS-1:0]  entry,
   output logic                  match,
   output logic                  found_right
);

   logic [PAGE_BITS-1:0] entry_ff;
   logic [PAGE_BITS-1:0] entry_in;
   logic                 shift;

   // Compare against the page; only filled cells may match.
   assign match       = ctrl.valid && (entry_ff == page);
   assign found_right = found_left || match;

   // On a hit every cell up to and including the hit shifts; on a miss the
   // cells of the insert region shift.
   assign shift    = ctrl.go && (ctrl.hit ? !found_left : ctrl.ins);
   assign entry_in = shift ? left_entry : entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### hdl/lru_stack_distance.sv
// ----------------------------------------------------------------------------
// LRU stack distance
// Fully associative LRU stack of page numbers built from a row of cells.
// ----------------------------------------------------------------------------
// Each accepted page word is looked up combinationally and one result word
// (hit flag and depth from the MRU end) follows in the next cycle, so one
// word can be taken per clock while the result register is free or being
// drained. The cycle is set by the compare-and-shift row of cells: every cell
// compares its entry with the page and a found flag ripples along the row to
// pick the cells that shift. Writing the capacity register empties the stack
// and needs no clearing pass; capacities above the stack depth act as the
// full depth, and a capacity of zero makes every access miss.
module lru_stack_distance import lsd_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic [DEPTH_W-1:0]    rsp_depth,
   // Capacity register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_capacity
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CAP_W-1:0]       capacity_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CNT_W-1:0]       cap_eff;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [DEPTH_W-1:0]     rsp_depth_ff;
   logic                   accept;
   logic                   hit;
   logic [DEPTH_W-1:0]     depth_val;
   logic [STACK_DEPTH-1:0] match_vec;
   logic [STACK_DEPTH-1:0] first_vec;
   logic [STACK_DEPTH:0]   found_chain;
   logic [PAGE_BITS-1:0]   entries [STACK_DEPTH];

   // Handshakes: a new word is taken whenever the result slot can be refilled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Capacities beyond the stack depth saturate to the depth.
   always_comb begin
      if (CMP_W'(capacity_ff) > CMP_W'(STACK_DEPTH)) begin
         cap_eff = CNT_W'(STACK_DEPTH);
      end else begin
         cap_eff = CNT_W'(capacity_ff);
      end
   end

   // The row of cells, with the found flag rippling from the MRU end.
   assign found_chain[0] = 1'b0;
   assign hit            = found_chain[STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      lsd_cell_ctrl_type     ctrl;
      logic [PAGE_BITS-1:0]  left_entry;

      assign ctrl.go    = accept;
      assign ctrl.hit   = hit;
      assign ctrl.valid = CNT_W'(i) < count_ff;
      assign ctrl.ins   = (CNT_W'(i) <= count_ff) && (CNT_W'(i) < cap_eff);

      if (i == 0) begin : g_head
         assign left_entry = req_page_number;
      end else begin : g_body
         assign left_entry = entries[i-1];
      end

      lsd_cell #(
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .page        (req_page_number),
         .left_entry  (left_entry),
         .found_left  (found_chain[i]),
         .entry       (entries[i]),
         .match       (match_vec[i]),
         .found_right (found_chain[i+1])
      );

      assign first_vec[i] = match_vec[i] && !found_chain[i];
   end

   // Encode the hit position; the depth field keeps its low bits only.
   always_comb begin
      depth_val = '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (first_vec[i]) begin
            depth_val = depth_val | DEPTH_W'(i);
         end
      end
   end

   // Fill count: unchanged on a hit, grows up to the capacity on a miss.
   always_comb begin
      if (hit || (count_ff >= cap_eff)) begin
         count_in = hit ? count_ff : cap_eff;
      end else begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Register, fill count and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
            count_ff    <= '0;
         end else if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff   <= hit;
         rsp_depth_ff <= hit ? depth_val : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_depth = rsp_depth_ff;

`ifndef ASSERT_OFF
   // The fill count never runs past the usable capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("fill count exceeds capacity");

   // Filled entries are distinct, so at most one cell matches.
   a_unique : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page held in more than one cell");

   // A page that is kept ends up at the MRU end.
   a_mru : assert property (@(posedge clock) disable iff (reset)
      accept && !(csr_valid && csr_ready) && (hit || (cap_eff != '0))
      |=> entries[0] == $past(req_page_number))
      else $error("looked-up page not at MRU position");

   // A hit leaves the fill count alone.
   a_hit_count : assert property (@(posedge clock) disable iff (reset)
      accept && hit && !(csr_valid && csr_ready) |=> count_ff == $past(count_ff))
      else $error("fill count changed on a hit");
`endif

endmodule

### tb/lru_depth_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU stack distance checker
// Watches the request, response and capacity channels of the LRU stack. It
// keeps its own copy of the stack, works out the hit flag and depth of every
// accepted page word and compares each accepted response word with the
// oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module lru_depth_checker import lsd_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_hit,
   input  logic [DEPTH_W-1:0]    rsp_depth,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_capacity,
   output int                    mismatch_count,
   output int                    pending_lookups
);

   typedef struct packed {
      logic                hit;
      logic [DEPTH_W-1:0]  depth;
   } lookup_result_type;

   // Shadow copy of the stack, MRU entry at position 0.
   logic [PAGE_BITS-1:0] page_stack [STACK_DEPTH];
   int                   stack_fill;
   logic [CAP_W-1:0]     frame_limit;

   lookup_result_type expected_lookups [$];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $realtime, what);
   endtask

   // Looks one page up in the shadow stack, updates it and yields the
   // response word that the block must produce for it.
   task automatic predict_lookup(input logic [PAGE_BITS-1:0] page,
                                 output lookup_result_type result);
      int frames;
      int used;
      int found;
      int last;
      int i;
      frames = (frame_limit > STACK_DEPTH) ? STACK_DEPTH : int'(frame_limit);
      used   = (stack_fill > frames) ? frames : stack_fill;
      found  = -1;
      result = '0;
      for (i = 0; i < used; i++) begin
         if (found < 0 && page_stack[i] == page) begin
            found = i;
         end
      end
      if (found >= 0) begin
         // Hit: the entry moves to the MRU end, the ones above it slide down.
         for (i = found; i > 0; i--) begin
            page_stack[i] = page_stack[i-1];
         end
         page_stack[0] = page;
         stack_fill    = used;
         result.hit    = 1'b1;
         result.depth  = DEPTH_W'(found);
      end else if (frames > 0) begin
         // Miss: insert at the MRU end, the LRU entry drops out when full.
         last = (used < frames) ? used : frames - 1;
         for (i = last; i > 0; i--) begin
            page_stack[i] = page_stack[i-1];
         end
         page_stack[0] = page;
         stack_fill    = (used < frames) ? used + 1 : frames;
      end else begin
         stack_fill = 0;
      end
   endtask

   always @(posedge clock) begin
      lookup_result_type predicted;
      lookup_result_type oldest;
      if (reset) begin
         stack_fill  = 0;
         frame_limit = CAP_RESET;
         expected_lookups.delete();
      end else begin
         // A capacity write also empties the stack.
         if (csr_valid && csr_ready) begin
            frame_limit = csr_capacity;
            stack_fill  = 0;
         end

         // Every accepted page word yields exactly one response word.
         if (req_valid && !req_stall) begin
            predict_lookup(req_page_number, predicted);
            expected_lookups.push_back(predicted);
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch($sformatf("response word hit=%b depth=%0d with no lookup waiting",
                                         rsp_hit, rsp_depth));
            end else begin
               oldest = expected_lookups.pop_front();
               if (rsp_hit !== oldest.hit) begin
                  report_mismatch($sformatf("hit: got %b, predicted %b",
                                            rsp_hit, oldest.hit));
               end
               if (rsp_depth !== oldest.depth) begin
                  report_mismatch($sformatf("depth: got %0d, predicted %0d",
                                            rsp_depth, oldest.depth));
               end
            end
         end
      end
      pending_lookups = expected_lookups.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU stack distance testbench
// Drives page words into the LRU stack under random idling on both channels
// and several capacity settings; the checker beside the block predicts and
// compares every response word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import lsd_pkg::*;

   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 72;
   localparam int HOLD_CYCLES = 48;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PAGE_BITS_DEF-1:0] req_page_number;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_hit;
   logic [DEPTH_W-1:0]    rsp_depth;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_capacity;
   int                    mismatch_count;
   int                    pending_lookups;

   // Phase-wide idling switch and the request for one long receiver hold-off.
   bit steady;
   bit long_hold_req;

   lru_stack_distance dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_depth       (rsp_depth),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   lru_depth_checker lookup_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_depth       (rsp_depth),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity),
      .mismatch_count  (mismatch_count),
      .pending_lookups (pending_lookups)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle length: mostly none, sometimes short, now and then long.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offers one page word after an optional gap and waits until it is taken.
   task automatic send_page(input logic [PAGE_BITS_DEF-1:0] page, input bit no_gap);
      int gap;
      gap = (steady || no_gap) ? 0 : draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid       <= 1'b0;
         req_page_number <= $urandom;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering and waits until every response word has come back.
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_lookups != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (long_hold_req) begin
               long_hold_req = 1'b0;
               stall_left    = HOLD_CYCLES;
            end else if (!steady && $urandom_range(3) == 0) begin
               stall_left = draw_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int                     phase;
      int                     k;
      int                     r;
      int                     frames;
      int                     pool_size;
      logic [CAP_W-1:0]       cap;
      logic [PAGE_BITS_DEF-1:0] page;
      logic [PAGE_BITS_DEF-1:0] page_pool [40];

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_page_number <= '0;
      csr_valid       <= 1'b0;
      csr_capacity    <= '0;
      steady          = 1'b0;
      long_hold_req   = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Extremes of the page field, each then hit at depth one.
      send_page('0, 1'b0);
      send_page('1, 1'b0);
      send_page('0, 1'b0);
      send_page('1, 1'b0);
      // Fifteen fresh pages overflow the full stack and push page zero out.
      for (k = 1; k <= 15; k++) begin
         send_page(32'h5A5A_0000 + k, 1'b0);
      end
      // The all-ones page now sits at the deepest position; page zero is gone.
      send_page('1, 1'b0);
      send_page('0, 1'b0);

      // Capacity zero: a repeated page still misses.
      quiesce();
      write_capacity(5'd0);
      send_page(32'h0000_1234, 1'b0);
      send_page(32'h0000_1234, 1'b0);

      // Capacity above the stack depth acts as the full depth.
      quiesce();
      write_capacity(5'd31);
      send_page(32'h0000_1234, 1'b0);
      send_page(32'h0000_1234, 1'b0);

      // Random phases: reuse from a small page pool so that hits reach every
      // depth, with some fresh pages and some one-bit neighbours of pool pages.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       cap = 5'd16;
            1:       cap = 5'd1;
            2:       cap = 5'd31;
            3:       cap = 5'd0;
            4:       cap = 5'd17;
            5:       cap = 5'd2;
            default: cap = CAP_W'($urandom_range(3, 15));
         endcase
         frames    = (cap > STACK_DEPTH_DEF) ? STACK_DEPTH_DEF : int'(cap);
         pool_size = $urandom_range(1, frames + frames / 2 + 2);
         for (k = 0; k < pool_size; k++) begin
            r = $urandom_range(19);
            page_pool[k] = (r == 0) ? '0 : (r == 1) ? '1 : PAGE_BITS_DEF'($urandom);
         end

         quiesce();
         steady = (phase == 5 || phase == 8);
         write_capacity(cap);

         for (k = 0; k < PHASE_ITEMS; k++) begin
            // Long receiver hold-off while the sender keeps offering.
            if (phase == 2 && k == 20) long_hold_req = 1'b1;
            // Sender pauses until all responses are back.
            if (phase == 4 && k == 36) quiesce();
            r = $urandom_range(99);
            if (r < 85) begin
               page = page_pool[$urandom_range(pool_size - 1)];
            end else if (r < 92) begin
               page = $urandom;
            end else begin
               page = page_pool[$urandom_range(pool_size - 1)]
                      ^ (PAGE_BITS_DEF'(1) << $urandom_range(PAGE_BITS_DEF - 1));
            end
            send_page(page, phase == 2 && k >= 20 && k < 40);
         end
      end

      quiesce();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
